// File: sv/color_blend_unit_assert.svh
// ----------------------------------------------------------------------------
// color_blend_unit assertion macros
// Concurrent checks on the block clock; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef COLOR_BLEND_UNIT_ASSERT_SVH
`define COLOR_BLEND_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define CBU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked in every cycle, reset included
`define CBU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CBU_ASSERT(lbl, prop, msg)
`define CBU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/cbu_pkg.sv
// ----------------------------------------------------------------------------
// cbu_pkg
// Types, codes and helper functions shared by the colour blend pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbu_pkg;

   localparam int CHAN_W   = 8;
   localparam int PROD_W   = 2 * CHAN_W;
   localparam int NUM_CHAN = 3;
   localparam int CSR_W    = 4;

   localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [PROD_W-1:0] FULL_SQ    = 16'd65025;
   localparam logic [PROD_W-1:0] ROUND_HALF = 16'd127;

   typedef enum logic [1:0] {
      CSR_MIX_OP     = 2'd0,
      CSR_SRC_FACTOR = 2'd1,
      CSR_DST_FACTOR = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_SUB     = 2'd1,
      OP_REV_SUB = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      FACTOR_ZERO          = 4'd0,
      FACTOR_ONE           = 4'd1,
      FACTOR_SRC_COL       = 4'd2,
      FACTOR_INV_SRC_COL   = 4'd3,
      FACTOR_SRC_ALPHA     = 4'd4,
      FACTOR_INV_SRC_ALPHA = 4'd5,
      FACTOR_DST_ALPHA     = 4'd6,
      FACTOR_INV_DST_ALPHA = 4'd7,
      FACTOR_DST_COL       = 4'd8,
      FACTOR_INV_DST_COL   = 4'd9
   } factor_type;

   typedef struct packed {
      logic [1:0] mix_op;
      logic [3:0] src_factor;
      logic [3:0] dst_factor;
   } cfg_type;

   // lowest field in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0] dst_alpha;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_red;
   } pixel_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][PROD_W-1:0] ts;
      logic [NUM_CHAN-1:0][PROD_W-1:0] td;
   } prod_type;

   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] sum_type;
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] color_type;

   // blend weight in 0..255 standing for 0.0..1.0; unused codes give zero
   function automatic logic [CHAN_W-1:0] blend_weight(
      input logic [3:0]        code,
      input logic [CHAN_W-1:0] c_s,
      input logic [CHAN_W-1:0] a_s,
      input logic [CHAN_W-1:0] c_d,
      input logic [CHAN_W-1:0] a_d
   );
      logic [CHAN_W-1:0] w;
      unique case (code)
         FACTOR_ONE:           w = FULL_SCALE;
         FACTOR_SRC_COL:       w = c_s;
         FACTOR_INV_SRC_COL:   w = FULL_SCALE - c_s;
         FACTOR_SRC_ALPHA:     w = a_s;
         FACTOR_INV_SRC_ALPHA: w = FULL_SCALE - a_s;
         FACTOR_DST_ALPHA:     w = a_d;
         FACTOR_INV_DST_ALPHA: w = FULL_SCALE - a_d;
         FACTOR_DST_COL:       w = c_d;
         FACTOR_INV_DST_COL:   w = FULL_SCALE - c_d;
         default:              w = '0;
      endcase
      return w;
   endfunction

   // round(v / 255), halves up; v <= 65025 so x stays below 2^16
   // floor(x / 255) == (x + (x >> 8) + 1) >> 8 for any x up to 65152, the largest x here
   function automatic logic [CHAN_W-1:0] div255_round(input logic [PROD_W-1:0] v);
      logic [PROD_W-1:0] x;
      logic [PROD_W-1:0] y;
      x = v + ROUND_HALF;
      y = x + (x >> CHAN_W) + PROD_W'(1);
      return y[PROD_W-1:CHAN_W];
   endfunction

endpackage

`default_nettype wire

// File: sv/cbu_mul_stage.sv
// ----------------------------------------------------------------------------
// cbu_mul_stage
// First stage: picks the blend weights and forms the six 8x8 products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "color_blend_unit_assert.svh"

module cbu_mul_stage import cbu_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire pixel_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output prod_type       out_data
);

   logic     valid_ff, valid_in;
   prod_type prod_ff, prod_in;

   logic [NUM_CHAN-1:0][CHAN_W-1:0] c_s, c_d;

   assign c_s = {in_data.src_blue, in_data.src_green, in_data.src_red};
   assign c_d = {in_data.dst_blue, in_data.dst_green, in_data.dst_red};

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         prod_in.ts[k] = PROD_W'(c_s[k]) * PROD_W'(blend_weight(cfg.src_factor, c_s[k],
                         in_data.src_alpha, c_d[k], in_data.dst_alpha));
         prod_in.td[k] = PROD_W'(c_d[k]) * PROD_W'(blend_weight(cfg.dst_factor, c_s[k],
                         in_data.src_alpha, c_d[k], in_data.dst_alpha));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = prod_ff;

   // a stalled item keeps its products
   `CBU_ASSERT(a_mul_hold, valid_ff && !out_ready |=> valid_ff && $stable(prod_ff), "mul stage lost a stalled item")

endmodule

`default_nettype wire

// File: sv/cbu_comb_stage.sv
// ----------------------------------------------------------------------------
// cbu_comb_stage
// Second stage: adds or subtracts the weighted terms and clamps to zero and full scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "color_blend_unit_assert.svh"

module cbu_comb_stage import cbu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire prod_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output sum_type       out_data
);

   logic    valid_ff, valid_in;
   sum_type sum_ff, sum_in;

   logic [PROD_W:0] total;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      total  = '0;
      sum_in = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         total = {1'b0, in_data.ts[k]} + {1'b0, in_data.td[k]};
         case (cfg.mix_op)
            OP_SUB:
               sum_in[k] = (in_data.ts[k] > in_data.td[k]) ?
                           in_data.ts[k] - in_data.td[k] : '0;
            OP_REV_SUB:
               sum_in[k] = (in_data.td[k] > in_data.ts[k]) ?
                           in_data.td[k] - in_data.ts[k] : '0;
            // add, and the spare code too
            default:
               sum_in[k] = (total > {1'b0, FULL_SQ}) ? FULL_SQ : total[PROD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = sum_ff;

   `CBU_ASSERT(a_comb_range, valid_ff |-> sum_ff[0] <= FULL_SQ && sum_ff[1] <= FULL_SQ && sum_ff[2] <= FULL_SQ, "blend sum above full scale")
   `CBU_ASSERT(a_comb_hold, valid_ff && !out_ready |=> valid_ff && $stable(sum_ff), "comb stage lost a stalled item")

endmodule

`default_nettype wire

// File: sv/cbu_div_stage.sv
// ----------------------------------------------------------------------------
// cbu_div_stage
// Last stage: rounding divide by 255 into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbu_div_stage import cbu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire sum_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output color_type    out_data
);

   logic      valid_ff, valid_in;
   color_type color_ff, color_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         color_in[k] = div255_round(in_data[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         color_ff <= color_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = color_ff;

endmodule

`default_nettype wire

// File: sv/color_blend_unit.sv
// ----------------------------------------------------------------------------
// color_blend_unit
// RGB blend stage of an output merger: weighted source and destination
// colour, combined by add, subtract or reverse subtract, saturated to 8 bits.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock while rsp_tready keeps the pipeline moving
// and returns one blended RGB pixel per item, in order. There is one register
// stage each for the weight multiply, the add/subtract with clamp and the
// rounding divide by 255, the last being the output register: an accepted
// item passes these registers in that order before it raises rsp_tvalid.
// Each stage holds its item while stalled and fills bubbles, so a stall on
// rsp_tready costs nothing once released. Factor codes 10..15 act as zero,
// op code 3 as add. Write the csr_ registers only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "color_blend_unit_assert.svh"

module color_blend_unit import cbu_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   // configuration writes
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_addr,
   input  wire logic [CSR_W-1:0] csr_wdata,
   // pixel pair in
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
   input  wire logic [63:0]      req_tdata,
   // blended pixel out
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // out_red, out_green, out_blue
   output logic [23:0]           rsp_tdata
);

   cfg_type   cfg_ff;
   pixel_type pixel;
   prod_type  prod;
   sum_type   sum;
   color_type color;

   logic mul_valid, comb_ready;
   logic comb_valid, div_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mix_op     <= OP_ADD;
         cfg_ff.src_factor <= FACTOR_ONE;
         cfg_ff.dst_factor <= FACTOR_ZERO;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIX_OP:     cfg_ff.mix_op     <= csr_wdata[1:0];
            CSR_SRC_FACTOR: cfg_ff.src_factor <= csr_wdata;
            CSR_DST_FACTOR: cfg_ff.dst_factor <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pixel = pixel_type'(req_tdata);

   cbu_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pixel),
      .out_valid (mul_valid),
      .out_ready (comb_ready),
      .out_data  (prod)
   );

   cbu_comb_stage u_comb (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mul_valid),
      .in_ready  (comb_ready),
      .in_data   (prod),
      .out_valid (comb_valid),
      .out_ready (div_ready),
      .out_data  (sum)
   );

   cbu_div_stage u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (comb_valid),
      .in_ready  (div_ready),
      .in_data   (sum),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (color)
   );

   assign rsp_tdata = color;

   `CBU_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && !mul_valid && !comb_valid, "pipeline not empty after reset")
   // nothing may reach the output without passing the middle stage
   `CBU_ASSERT(a_no_skip, !rsp_tvalid && !comb_valid |=> !rsp_tvalid, "item appeared from an empty pipeline")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: colour blend unit testbench
// Drives pixel pairs through the blend stage under a series of op and factor
// settings. A directed table covers the corner cases, and random phases with
// varied back-pressure follow. Every blended pixel is checked against an
// expected value, typed in the table or taken from a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import cbu_pkg::*; ();

   // codes outside the named set; the block treats op 3 as add and factors 10..15 as zero
   localparam logic [3:0] OP_UNUSED        = 4'd3;
   localparam logic [3:0] OP_REV_SUB_WIDE  = 4'hE;   // masks down to reverse subtract
   localparam logic [3:0] FACTOR_UNUSED_LO = 4'd10;
   localparam logic [3:0] FACTOR_UNUSED_HI = 4'd15;

   localparam int NUM_PHASES   = 12;
   localparam int PHASE_PIXELS = 150;
   localparam int LONG_HOLD    = 60;
   localparam int CYCLE_LIMIT  = 400000;

   // red in the lowest byte, as on rsp_tdata
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef struct packed {
      logic [3:0] op, sf, df;
      logic [7:0] sr, sg, sb, sa, dr, dg, db, da;
      logic       typed;
      logic [7:0] er, eg, eb;
   } dir_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = CSR_MIX_OP;
   logic [3:0]  csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;

   rgb_type     pending_rgb[$];
   rgb_type     due_rgb;
   rgb_type     rsp_rgb;
   cfg_type     blend_cfg     = '{OP_ADD, FACTOR_ONE, FACTOR_ZERO};
   logic [11:0] written_cfg   = {4'(OP_ADD), 4'(FACTOR_ONE), 4'(FACTOR_ZERO)};
   int          mismatch_count = 0;
   int          checked_count  = 0;
   int          cycle_count    = 0;
   int          setting_count  = 0;
   int          rsp_stall_pct  = 0;
   int          hold_left      = 0;
   logic        hold_request   = 1'b0;

   assign rsp_rgb = rsp_tdata;

   color_blend_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // op, sf, df, src rgba, dst rgba, typed, expected rgb
   dir_row_type dir_tab [0:22] = '{
      '{OP_ADD, FACTOR_ONE, FACTOR_ZERO, 8'h12, 8'h34, 8'h56, 8'h78,
        8'h9a, 8'hbc, 8'hde, 8'hf0, 1'b1, 8'h12, 8'h34, 8'h56},
      '{OP_ADD, FACTOR_ONE, FACTOR_ZERO, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, 8'hff},
      '{OP_ADD, FACTOR_ONE, FACTOR_ZERO, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_ONE, FACTOR_ONE, 8'hc8, 8'hc8, 8'hc8, 8'h00,
        8'hc8, 8'hc8, 8'hc8, 8'h00, 1'b1, 8'hff, 8'hff, 8'hff},
      '{OP_ADD, FACTOR_ONE, FACTOR_ONE, 8'h40, 8'h20, 8'h00, 8'hff,
        8'h30, 8'h10, 8'h00, 8'hff, 1'b1, 8'h70, 8'h30, 8'h00},
      '{OP_SUB, FACTOR_ONE, FACTOR_ONE, 8'h0a, 8'h0a, 8'h0a, 8'h55,
        8'hc8, 8'hc8, 8'hc8, 8'haa, 1'b1, 8'h00, 8'h00, 8'h00},
      '{OP_SUB, FACTOR_ONE, FACTOR_ONE, 8'hc8, 8'h80, 8'hff, 8'h00,
        8'h0a, 8'h80, 8'h00, 8'hff, 1'b1, 8'hbe, 8'h00, 8'hff},
      '{OP_REV_SUB, FACTOR_ONE, FACTOR_ONE, 8'hc8, 8'hc8, 8'hc8, 8'hff,
        8'h0a, 8'h0a, 8'h0a, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
      '{OP_REV_SUB, FACTOR_ONE, FACTOR_ONE, 8'h0a, 8'h00, 8'h01, 8'h80,
        8'hc8, 8'hff, 8'h01, 8'h7f, 1'b1, 8'hbe, 8'hff, 8'h00},
      '{OP_UNUSED, FACTOR_ONE, FACTOR_ONE, 8'h64, 8'h32, 8'h00, 8'h01,
        8'h32, 8'h64, 8'hff, 8'hfe, 1'b1, 8'h96, 8'h96, 8'hff},
      '{OP_ADD, FACTOR_UNUSED_HI, FACTOR_ONE, 8'h11, 8'h22, 8'h33, 8'h44,
        8'h4d, 8'h4e, 8'h4f, 8'h50, 1'b1, 8'h4d, 8'h4e, 8'h4f},
      '{OP_ADD, FACTOR_ONE, FACTOR_UNUSED_HI, 8'ha1, 8'hb2, 8'hc3, 8'hd4,
        8'he5, 8'hf6, 8'h07, 8'h18, 1'b1, 8'ha1, 8'hb2, 8'hc3},
      '{OP_ADD, FACTOR_UNUSED_LO, FACTOR_UNUSED_LO, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_ZERO, FACTOR_ZERO, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_SRC_ALPHA, FACTOR_INV_SRC_ALPHA, 8'h80, 8'h40, 8'hc0, 8'h80,
        8'h20, 8'he0, 8'h60, 8'hff, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_SRC_COL, FACTOR_DST_COL, 8'h9c, 8'h13, 8'hf0, 8'h3c,
        8'h77, 8'hd1, 8'h05, 8'h81, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_SUB, FACTOR_INV_SRC_COL, FACTOR_INV_DST_COL, 8'h21, 8'hfe, 8'h80, 8'h11,
        8'hc4, 8'h02, 8'h7f, 8'hee, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_REV_SUB, FACTOR_DST_ALPHA, FACTOR_INV_DST_ALPHA, 8'h5a, 8'ha5, 8'h0f, 8'hf0,
        8'he1, 8'h1e, 8'hb4, 8'h4b, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_INV_DST_ALPHA, FACTOR_DST_ALPHA, 8'hc3, 8'h3c, 8'h99, 8'h66,
        8'h81, 8'h7e, 8'h01, 8'hc0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_DST_COL, FACTOR_SRC_COL, 8'hff, 8'h80, 8'h01, 8'h00,
        8'hff, 8'h80, 8'hfe, 8'hff, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_SUB, FACTOR_INV_DST_COL, FACTOR_INV_SRC_COL, 8'h10, 8'hd0, 8'h6e, 8'h2a,
        8'h08, 8'h9f, 8'hf7, 8'hd5, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_REV_SUB_WIDE, FACTOR_INV_SRC_ALPHA, FACTOR_SRC_ALPHA, 8'h3f, 8'hbf, 8'h7f, 8'h40,
        8'hc0, 8'h40, 8'h80, 8'h3f, 1'b0, 8'h00, 8'h00, 8'h00},
      '{OP_ADD, FACTOR_SRC_ALPHA, FACTOR_INV_SRC_ALPHA, 8'h7f, 8'h80, 8'h01, 8'h7f,
        8'h80, 8'h7f, 8'hfe, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---- predictor ----
   function automatic logic [7:0] factor_value(input logic [3:0] code,
         input logic [7:0] cs, input logic [7:0] as, input logic [7:0] cd,
         input logic [7:0] ad);
      case (code)
         FACTOR_ONE:           return FULL_SCALE;
         FACTOR_SRC_COL:       return cs;
         FACTOR_INV_SRC_COL:   return FULL_SCALE - cs;
         FACTOR_SRC_ALPHA:     return as;
         FACTOR_INV_SRC_ALPHA: return FULL_SCALE - as;
         FACTOR_DST_ALPHA:     return ad;
         FACTOR_INV_DST_ALPHA: return FULL_SCALE - ad;
         FACTOR_DST_COL:       return cd;
         FACTOR_INV_DST_COL:   return FULL_SCALE - cd;
         default:              return '0;
      endcase
   endfunction

   function automatic logic [7:0] blend_chan(input logic [7:0] cs, input logic [7:0] as,
         input logic [7:0] cd, input logic [7:0] ad, input cfg_type c);
      int ts, td, v;
      ts = int'(cs) * int'(factor_value(c.src_factor, cs, as, cd, ad));
      td = int'(cd) * int'(factor_value(c.dst_factor, cs, as, cd, ad));
      case (c.mix_op)
         OP_SUB:     v = ts - td;
         OP_REV_SUB: v = td - ts;
         default:    v = ts + td;
      endcase
      if (v < 0) v = 0;
      if (v > int'(FULL_SQ)) v = int'(FULL_SQ);
      return 8'((v + int'(ROUND_HALF)) / int'(FULL_SCALE));
   endfunction

   function automatic rgb_type predict_rgb(input pixel_type px, input cfg_type c);
      rgb_type res;
      res.red   = blend_chan(px.src_red, px.src_alpha, px.dst_red, px.dst_alpha, c);
      res.green = blend_chan(px.src_green, px.src_alpha, px.dst_green, px.dst_alpha, c);
      res.blue  = blend_chan(px.src_blue, px.src_alpha, px.dst_blue, px.dst_alpha, c);
      return res;
   endfunction

   // saturating values turn up often enough to hit the clamps
   function automatic logic [7:0] rand_chan();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [3:0] rand_factor();
      if ($urandom_range(3) == 0) return 4'($urandom_range(15));
      return 4'($urandom_range(9));
   endfunction

   // ---- driving ----
   task automatic send_pixel(input pixel_type px, input rgb_type want, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      pending_rgb.push_back(want);
   endtask

   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rgb.size() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [3:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MIX_OP:     blend_cfg.mix_op     = val[1:0];
         CSR_SRC_FACTOR: blend_cfg.src_factor = val;
         CSR_DST_FACTOR: blend_cfg.dst_factor = val;
         default: ;
      endcase
   endtask

   task automatic load_blend(input logic [3:0] op, input logic [3:0] sf, input logic [3:0] df);
      drain_pixels();
      write_csr(CSR_MIX_OP, op);
      write_csr(CSR_SRC_FACTOR, sf);
      write_csr(CSR_DST_FACTOR, df);
      csr_we <= 1'b0;
      written_cfg = {op, sf, df};
      setting_count++;
   endtask

   // ---- receiver back-pressure ----
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---- result checking ----
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rgb.size() == 0) begin
            $error("blended pixel %h with no item outstanding", rsp_tdata);
            mismatch_count++;
         end else begin
            due_rgb = pending_rgb.pop_front();
            checked_count++;
            if (rsp_rgb.red !== due_rgb.red) begin
               $error("out_red: expected %0d, got %0d", due_rgb.red, rsp_rgb.red);
               mismatch_count++;
            end
            if (rsp_rgb.green !== due_rgb.green) begin
               $error("out_green: expected %0d, got %0d", due_rgb.green, rsp_rgb.green);
               mismatch_count++;
            end
            if (rsp_rgb.blue !== due_rgb.blue) begin
               $error("out_blue: expected %0d, got %0d", due_rgb.blue, rsp_rgb.blue);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---- stimulus ----
   initial begin : stimulus
      dir_row_type row;
      pixel_type   px;
      rgb_type     want;
      int          send_idle;
      logic [3:0]  op, sf, df;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners; the first rows run on the reset settings
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         if ({row.op, row.sf, row.df} != written_cfg) load_blend(row.op, row.sf, row.df);
         px = {row.da, row.db, row.dg, row.dr, row.sa, row.sb, row.sg, row.sr};
         if (row.typed) want = {row.eb, row.eg, row.er};
         else           want = predict_rgb(px, blend_cfg);
         send_pixel(px, want, 0);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin op = OP_ADD;     sf = FACTOR_ONE;  df = FACTOR_ONE;  end
            1: begin op = OP_SUB;     sf = FACTOR_ONE;  df = FACTOR_ONE;  end
            2: begin op = OP_REV_SUB; sf = FACTOR_ZERO; df = FACTOR_ONE;  end
            default: begin
               op = 4'($urandom_range(15));
               sf = rand_factor();
               df = rand_factor();
            end
         endcase
         load_blend(op, sf, df);
         case (ph % 4)
            0:       begin send_idle = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle = 77; rsp_stall_pct = 0;  end
            2:       begin send_idle = 0;  rsp_stall_pct = 77; end
            default: begin send_idle = 6;  rsp_stall_pct = 6;  end
         endcase
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // long receiver hold with the sender still pushing: pipeline fills
            if (ph == 4 && n == 40) hold_request = 1'b1;
            // sender waits for the pipeline to empty mid-phase
            if (ph == 5 && n == 75) drain_pixels();
            for (int k = 0; k < 8; k++) px[k*8 +: 8] = rand_chan();
            send_pixel(px, predict_rgb(px, blend_cfg), send_idle);
         end
      end

      rsp_stall_pct = 0;
      drain_pixels();
      repeat (8) @(posedge clock);
      if (pending_rgb.size() != 0) begin
         $error("%0d blended pixels never arrived", pending_rgb.size());
         mismatch_count++;
      end

      $display("Ran %0d directed and %0d random pixel pairs over %0d blend settings",
               $size(dir_tab), NUM_PHASES * PHASE_PIXELS, setting_count);
      $display("%0d blended pixels checked, %0d field errors", checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
